[hw/rtl/ipl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipl_pkg;

  // Field widths of one item and one result
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned PointW  = 2 * CoordW;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // Default store depth and the widths that follow from it
  localparam int unsigned DefDepth = 64;
  localparam int unsigned DefAw    = $clog2(DefDepth);
  localparam int unsigned DefCw    = $clog2(DefDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_END   = 3'd4,
    CMD_REM_AT    = 3'd5,
    CMD_GET       = 3'd6,
    CMD_SET       = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // What the back end has to do with the store for one item
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_INS   = 3'd3,
    OP_REM   = 3'd4
  } op_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SHIFT = 2'd1,
    BK_PUT   = 2'd2,
    BK_RESP  = 2'd3
  } back_state_e;

  // Decoded item at the default depth
  typedef struct packed {
    op_kind_e          kind;
    logic              shift;
    logic [DefAw-1:0]  first_idx;
    logic [DefAw-1:0]  last_idx;
    logic [DefAw-1:0]  idx;
    status_e           status;
    logic [DefCw-1:0]  count;
    logic [PointW-1:0] point;
  } op_t;

endpackage

`default_nettype wire

[hw/rtl/indexed_point_list_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to DEPTH (x, y) points with insert and remove at the
// front, the end or a position k and get and set at a position k; every
// command returns one result with a status, the point read by a get (zero
// otherwise) and the count afterwards. A failed command (empty list, index out
// of range, list full) leaves the store untouched. The front end decodes
// commands against its own count and queues them two deep; the back end works
// through a point memory with one write port and one registered read port and
// takes a new command only once the result of the last one is loaded. A
// positional insert or remove shifts the later entries one per cycle through
// the one memory write port. The store needs no clearing after reset.
module indexed_point_list_store #(
  parameter int unsigned DEPTH = ipl_pkg::DefDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ipl_pkg::CmdW-1:0]           command_i,
  input  logic [ipl_pkg::PosW-1:0]           position_i,
  input  logic signed [ipl_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [ipl_pkg::CoordW-1:0]  point_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ipl_pkg::StatusW-1:0]        status_o,
  output logic signed [ipl_pkg::CoordW-1:0]  read_x_o,
  output logic signed [ipl_pkg::CoordW-1:0]  read_y_o,
  output logic [ipl_pkg::CountW-1:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    ipl_pkg::op_kind_e          kind;
    logic                       shift;
    logic [AW-1:0]              first_idx;
    logic [AW-1:0]              last_idx;
    logic [AW-1:0]              idx;
    ipl_pkg::status_e           status;
    logic [CW-1:0]              count;
    logic [ipl_pkg::PointW-1:0] point;
  } op_item_t;

  op_item_t push_op, pop_op;
  logic     push_valid, push_ready, pop_valid, pop_ready;

  ipl_front #(
    .Depth (DEPTH),
    .op_t  (op_item_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  ipl_queue #(
    .item_t (op_item_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_op)
  );

  ipl_back #(
    .Depth (DEPTH),
    .op_t  (op_item_t)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_op_i      (pop_op),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_x_o      (read_x_o),
    .read_y_o      (read_y_o),
    .entry_count_o (entry_count_o)
  );

  // A failed command never returns point data
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ipl_pkg::ST_OK |-> read_x_o == '0 && read_y_o == '0)
    else $error("error result carries point data");

  // An empty-list error reports an empty store
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ipl_pkg::ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with nonzero count");

  // A full error reports a store at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ipl_pkg::ST_FULL
    |-> entry_count_o == ipl_pkg::CountW'(DEPTH))
    else $error("full status with count below capacity");

endmodule

`default_nettype wire

[hw/rtl/ipl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipl_front #(
  parameter int unsigned Depth = ipl_pkg::DefDepth,
  parameter type op_t = ipl_pkg::op_t
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ipl_pkg::CmdW-1:0]           command_i,
  input  logic [ipl_pkg::PosW-1:0]           position_i,
  input  logic signed [ipl_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [ipl_pkg::CoordW-1:0]  point_y_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output op_t                                push_op_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned W  = (CW > ipl_pkg::PosW) ? CW : ipl_pkg::PosW;

  logic [CW-1:0] count_q, count_d;
  logic [W-1:0]  cnt_w, pos_w, ins_k, rem_k;
  ipl_pkg::cmd_e cmd;
  op_t           op;
  logic          accept;

  assign cmd    = ipl_pkg::cmd_e'(command_i);
  assign cnt_w  = W'(count_q);
  assign pos_w  = W'(position_i);
  assign accept = in_valid_i & push_ready_i;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_op_o    = op;

  // Pick the target position of insert and remove commands
  always_comb begin
    ins_k = pos_w;
    rem_k = pos_w;
    case (cmd)
      ipl_pkg::CMD_INS_FRONT: ins_k = '0;
      ipl_pkg::CMD_INS_END:   ins_k = cnt_w;
      ipl_pkg::CMD_REM_FRONT: rem_k = '0;
      ipl_pkg::CMD_REM_END:   rem_k = cnt_w - W'(1);
      default: begin
        ins_k = pos_w;
        rem_k = pos_w;
      end
    endcase
  end

  // Classify the item against the current count
  always_comb begin
    op           = '0;
    op.kind      = ipl_pkg::OP_NONE;
    op.status    = ipl_pkg::ST_OK;
    op.count     = count_q;
    op.point     = {point_y_i, point_x_i};
    case (cmd)
      ipl_pkg::CMD_INS_FRONT, ipl_pkg::CMD_INS_END, ipl_pkg::CMD_INS_AT: begin
        if (ins_k > cnt_w) begin
          op.status = ipl_pkg::ST_RANGE;
        end else if (cnt_w == W'(Depth)) begin
          op.status = ipl_pkg::ST_FULL;
        end else begin
          op.kind      = ipl_pkg::OP_INS;
          op.shift     = cnt_w > ins_k;
          op.first_idx = AW'(cnt_w - W'(1));
          op.last_idx  = AW'(ins_k);
          op.idx       = AW'(ins_k);
          op.count     = count_q + CW'(1);
        end
      end
      ipl_pkg::CMD_REM_FRONT, ipl_pkg::CMD_REM_END, ipl_pkg::CMD_REM_AT: begin
        if (cmd != ipl_pkg::CMD_REM_AT && cnt_w == '0) begin
          op.status = ipl_pkg::ST_EMPTY;
        end else if (rem_k >= cnt_w) begin
          op.status = ipl_pkg::ST_RANGE;
        end else begin
          op.kind      = ipl_pkg::OP_REM;
          op.shift     = (rem_k + W'(1)) < cnt_w;
          op.first_idx = AW'(rem_k + W'(1));
          op.last_idx  = AW'(cnt_w - W'(1));
          op.idx       = AW'(rem_k);
          op.count     = count_q - CW'(1);
        end
      end
      ipl_pkg::CMD_GET, ipl_pkg::CMD_SET: begin
        if (pos_w >= cnt_w) begin
          op.status = ipl_pkg::ST_RANGE;
        end else begin
          op.kind = (cmd == ipl_pkg::CMD_GET) ? ipl_pkg::OP_READ : ipl_pkg::OP_WRITE;
          op.idx  = AW'(pos_w);
        end
      end
      default: begin
        op.kind = ipl_pkg::OP_NONE;
      end
    endcase
  end

  // Track the count as items are accepted
  assign count_d = accept ? op.count : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ipl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipl_queue #(
  parameter type item_t = ipl_pkg::op_t
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_data_o
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ipl_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipl_back #(
  parameter int unsigned Depth = ipl_pkg::DefDepth,
  parameter type op_t = ipl_pkg::op_t
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  op_t                                pop_op_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ipl_pkg::StatusW-1:0]        status_o,
  output logic signed [ipl_pkg::CoordW-1:0]  read_x_o,
  output logic signed [ipl_pkg::CoordW-1:0]  read_y_o,
  output logic [ipl_pkg::CountW-1:0]         entry_count_o
);

  localparam int unsigned AW   = $clog2(Depth);
  localparam int unsigned CntW = ipl_pkg::CountW;
  localparam int unsigned CrdW = ipl_pkg::CoordW;

  ipl_pkg::back_state_e state_q, state_d;
  op_t                  op_q, op_d;
  logic [AW-1:0]        src_q, src_d, src_nxt;
  logic                 src_last, pop, out_free, out_load;
  logic                 out_valid_q, out_valid_d;

  // Store memory, single write and single registered read port
  logic [ipl_pkg::PointW-1:0] mem_q [Depth];
  logic [ipl_pkg::PointW-1:0] rd_data_q, wr_data;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic                       rd_en, wr_en;

  ipl_pkg::status_e           out_status_q;
  logic signed [CrdW-1:0]     out_x_q, out_y_q;
  logic [CntW-1:0]            out_count_q;

  assign pop_ready_o = (state_q == ipl_pkg::BK_IDLE);
  assign pop         = pop_valid_i & pop_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign src_nxt     = (op_q.kind == ipl_pkg::OP_INS) ? src_q - AW'(1) : src_q + AW'(1);
  assign src_last    = (src_q == op_q.last_idx);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipl_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          if ((pop_op_i.kind == ipl_pkg::OP_INS || pop_op_i.kind == ipl_pkg::OP_REM)
              && pop_op_i.shift) begin
            state_d = ipl_pkg::BK_SHIFT;
          end else if (pop_op_i.kind == ipl_pkg::OP_INS
                       || pop_op_i.kind == ipl_pkg::OP_WRITE) begin
            state_d = ipl_pkg::BK_PUT;
          end else begin
            state_d = ipl_pkg::BK_RESP;
          end
        end
      end
      ipl_pkg::BK_SHIFT: begin
        if (src_last) begin
          state_d = (op_q.kind == ipl_pkg::OP_INS) ? ipl_pkg::BK_PUT : ipl_pkg::BK_RESP;
        end
      end
      ipl_pkg::BK_PUT: state_d = ipl_pkg::BK_RESP;
      ipl_pkg::BK_RESP: begin
        if (out_free) begin
          state_d = ipl_pkg::BK_IDLE;
        end
      end
      default: state_d = ipl_pkg::BK_IDLE;
    endcase
  end

  // Memory ports, walk pointer and result load
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = src_nxt;
    wr_en    = 1'b0;
    wr_addr  = op_q.idx;
    wr_data  = op_q.point;
    src_d    = src_q;
    op_d     = op_q;
    out_load = 1'b0;
    case (state_q)
      ipl_pkg::BK_IDLE: begin
        if (pop) begin
          op_d  = pop_op_i;
          src_d = pop_op_i.first_idx;
          if (pop_op_i.kind == ipl_pkg::OP_READ) begin
            rd_en   = 1'b1;
            rd_addr = pop_op_i.idx;
          end else if (pop_op_i.shift) begin
            rd_en   = 1'b1;
            rd_addr = pop_op_i.first_idx;
          end
        end
      end
      ipl_pkg::BK_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = (op_q.kind == ipl_pkg::OP_INS) ? src_q + AW'(1) : src_q - AW'(1);
        wr_data = rd_data_q;
        if (!src_last) begin
          rd_en = 1'b1;
          src_d = src_nxt;
        end
      end
      ipl_pkg::BK_PUT: begin
        wr_en = 1'b1;
      end
      ipl_pkg::BK_RESP: begin
        out_load = out_free;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipl_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the current item and walk position
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    src_q <= src_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Load the result register; read fields only for a get
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= op_q.status;
      out_count_q  <= CntW'(op_q.count);
      if (op_q.kind == ipl_pkg::OP_READ) begin
        out_x_q <= rd_data_q[CrdW-1:0];
        out_y_q <= rd_data_q[2*CrdW-1:CrdW];
      end else begin
        out_x_q <= '0;
        out_y_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_x_o      = out_x_q;
  assign read_y_o      = out_y_q;
  assign entry_count_o = out_count_q;

endmodule

`default_nettype wire

[dv/indexed_point_list_store_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the point list, predicts one
// reply per accepted command and compares every accepted reply in order.
module indexed_point_list_store_checker
  import ipl_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [CmdW-1:0]          command_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [StatusW-1:0]       status_i,
  input  logic signed [CoordW-1:0] read_x_i,
  input  logic signed [CoordW-1:0] read_y_i,
  input  logic [CountW-1:0]        entry_count_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_o,
  output int unsigned              list_count_o
);

  localparam int unsigned ReportLimit = 10;

  typedef struct {
    cmd_e              op;
    logic [PosW-1:0]   k;
    status_e           status;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ry;
    logic [CountW-1:0] count;
  } list_reply_t;

  // Shadow list: x in the low half, y in the high half of each entry
  logic [PointW-1:0] shadow_points [DEPTH];
  int unsigned       shadow_count;
  list_reply_t       predicted_replies [$];
  int unsigned       failures;

  // Open a slot at k and store the point there
  function automatic status_e place_point(int unsigned k, logic [PointW-1:0] pt);
    if (k > shadow_count) return ST_RANGE;
    if (shadow_count >= DEPTH) return ST_FULL;
    for (int unsigned i = shadow_count; i > k; i--) begin
      shadow_points[i] = shadow_points[i - 1];
    end
    shadow_points[k] = pt;
    shadow_count++;
    return ST_OK;
  endfunction

  // Close the slot at k
  function automatic status_e drop_point(int unsigned k);
    if (k >= shadow_count) return ST_RANGE;
    for (int unsigned i = k; i + 1 < shadow_count; i++) begin
      shadow_points[i] = shadow_points[i + 1];
    end
    shadow_count--;
    return ST_OK;
  endfunction

  // Apply one command to the shadow list and build the reply it must produce
  function automatic list_reply_t apply_list_command(cmd_e op, logic [PosW-1:0] k,
                                                     logic [PointW-1:0] pt);
    list_reply_t r;
    r.op     = op;
    r.k      = k;
    r.status = ST_OK;
    r.rx     = '0;
    r.ry     = '0;
    case (op)
      CMD_INS_FRONT: r.status = place_point(0, pt);
      CMD_INS_END:   r.status = place_point(shadow_count, pt);
      CMD_INS_AT:    r.status = place_point(k, pt);
      CMD_REM_FRONT: r.status = (shadow_count == 0) ? ST_EMPTY : drop_point(0);
      CMD_REM_END:   r.status = (shadow_count == 0) ? ST_EMPTY : drop_point(shadow_count - 1);
      CMD_REM_AT:    r.status = drop_point(k);
      CMD_GET: begin
        if (k >= shadow_count) r.status = ST_RANGE;
        else {r.ry, r.rx} = shadow_points[k];
      end
      default: begin
        if (k >= shadow_count) r.status = ST_RANGE;
        else shadow_points[k] = pt;
      end
    endcase
    r.count = shadow_count[CountW-1:0];
    return r;
  endfunction

  // Retire replies before taking new commands: a reply never belongs to the
  // command accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      failures     = 0;
      predicted_replies.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      list_count_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          failures++;
          if (failures <= ReportLimit)
            $display("%0t: reply with none pending: status=%0d x=%0h y=%0h count=%0d",
                     $time, status_i, read_x_i, read_y_i, entry_count_i);
        end else begin
          want = predicted_replies.pop_front();
          if (status_i !== want.status || read_x_i !== want.rx ||
              read_y_i !== want.ry || entry_count_i !== want.count) begin
            failures++;
            if (failures <= ReportLimit) begin
              $write("%0t: %s k=%0d: expected status=%0d x=%0h y=%0h count=%0d, ",
                     $time, want.op.name(), want.k, want.status, want.rx, want.ry,
                     want.count);
              $display("got status=%0d x=%0h y=%0h count=%0d",
                       status_i, read_x_i, read_y_i, entry_count_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predicted_replies.push_back(apply_list_command(cmd_e'(command_i), position_i,
                                                       {point_y_i, point_x_i}));
      mismatch_count_o <= failures;
      pending_o        <= predicted_replies.size();
      list_count_o     <= shadow_count;
    end
  end

endmodule

[dv/indexed_point_list_store_tb.sv]
`timescale 1ns / 1ps

module indexed_point_list_store_tb;
  import ipl_pkg::*;

  localparam int unsigned DEPTH          = DefDepth;
  localparam int unsigned RandomItems    = 830;
  localparam int unsigned HoldAt         = 300;
  localparam int unsigned PauseAt        = 500;
  localparam int unsigned LongHold       = 300;
  localparam int unsigned SettleCycles   = DEPTH + 16;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned PhaseItemLimit = 300;

  localparam logic [CoordW-1:0] CoordMin  = 32'h8000_0000;
  localparam logic [CoordW-1:0] CoordMax  = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] CoordZero = 32'h0000_0000;
  localparam logic [CoordW-1:0] CoordOnes = 32'hffff_ffff;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  typedef struct {
    cmd_e              op;
    logic [PosW-1:0]   k;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } list_cmd_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [CmdW-1:0]          command_i;
  logic [PosW-1:0]          position_i;
  logic signed [CoordW-1:0] point_x_i;
  logic signed [CoordW-1:0] point_y_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [StatusW-1:0]       status_o;
  logic signed [CoordW-1:0] read_x_o;
  logic signed [CoordW-1:0] read_y_o;
  logic [CountW-1:0]        entry_count_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned list_count;
  int unsigned burst_left = 0;
  logic        long_hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  indexed_point_list_store #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_x_o     (read_x_o),
    .read_y_o     (read_y_o),
    .entry_count_o(entry_count_o)
  );

  indexed_point_list_store_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .read_x_i        (read_x_o),
    .read_y_i        (read_y_o),
    .entry_count_i   (entry_count_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .list_count_o    (list_count)
  );

  // Hold the item on the channel until it is accepted
  task automatic offer_item(input cmd_e op, input logic [PosW-1:0] k,
                            input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    in_valid_i <= 1'b1;
    command_i  <= op;
    position_i <= k;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Count down the current burst; at its end drop valid for a random gap
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
  endtask

  // Stop offering and wait until every predicted reply has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Steer the fill level toward the goal while mixing in reads and writes
  function automatic cmd_e pick_command(int unsigned fill, int unsigned goal);
    int unsigned ins_pct;
    int unsigned rem_pct;
    int unsigned r;
    if (fill + 1 < goal) begin
      ins_pct = 65;
      rem_pct = 10;
    end else if (fill > goal + 1) begin
      ins_pct = 10;
      rem_pct = 65;
    end else begin
      ins_pct = 38;
      rem_pct = 38;
    end
    r = $urandom_range(0, 99);
    if (r < ins_pct) return cmd_e'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
    if (r < ins_pct + rem_pct) return cmd_e'($urandom_range(CMD_REM_FRONT, CMD_REM_AT));
    return $urandom_range(0, 1) ? CMD_GET : CMD_SET;
  endfunction

  // Mostly in range (k = fill hits the edge), sometimes anywhere in the field
  function automatic logic [PosW-1:0] pick_position(int unsigned fill);
    if ($urandom_range(0, 99) < 85) return PosW'($urandom_range(0, fill));
    return PosW'($urandom_range(0, (1 << PosW) - 1));
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return CoordZero;
      3:       return CoordOnes;
      default: return $urandom;
    endcase
  endfunction

  // Reset, directed edge cases, then random phases that fill and empty the list
  initial begin : stimulus
    list_cmd_t   plan [$];
    int unsigned goal_plan [6];
    int unsigned sent;
    int unsigned phase;
    int unsigned goal;
    int unsigned hover_left;
    int unsigned phase_items;
    int unsigned fill;
    bit          reached;
    goal_plan = '{DEPTH, 0, 40, DEPTH, 5, 0};
    in_valid_i <= 1'b0;
    command_i  <= CMD_GET;
    position_i <= '0;
    point_x_i  <= '0;
    point_y_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list errors, range errors, extreme points, ignored fields
    plan.push_back('{CMD_REM_FRONT, 7'd0,   CoordOnes, CoordOnes});
    plan.push_back('{CMD_REM_END,   7'd127, CoordZero, CoordZero});
    plan.push_back('{CMD_REM_AT,    7'd0,   CoordZero, CoordZero});
    plan.push_back('{CMD_GET,       7'd0,   CoordZero, CoordZero});
    plan.push_back('{CMD_SET,       7'd0,   CoordMax,  CoordMin});
    plan.push_back('{CMD_INS_AT,    7'd1,   CoordMax,  CoordMax});
    plan.push_back('{CMD_INS_AT,    7'd127, CoordMin,  CoordMin});
    plan.push_back('{CMD_INS_AT,    7'd0,   CoordMin,  CoordMax});
    plan.push_back('{CMD_INS_FRONT, 7'd127, CoordMax,  CoordMin});
    plan.push_back('{CMD_INS_END,   7'd64,  CoordZero, CoordOnes});
    plan.push_back('{CMD_INS_AT,    7'd1,   CoordOnes, CoordZero});
    plan.push_back('{CMD_GET,       7'd0,   CoordOnes, CoordOnes});
    plan.push_back('{CMD_GET,       7'd3,   CoordZero, CoordZero});
    plan.push_back('{CMD_GET,       7'd4,   CoordZero, CoordZero});
    plan.push_back('{CMD_GET,       7'd64,  CoordZero, CoordZero});
    plan.push_back('{CMD_SET,       7'd2,   32'h5a5a_a5a5, 32'ha5a5_5a5a});
    plan.push_back('{CMD_GET,       7'd2,   CoordZero, CoordZero});
    plan.push_back('{CMD_REM_AT,    7'd1,   CoordOnes, CoordOnes});
    plan.push_back('{CMD_REM_AT,    7'd3,   CoordZero, CoordZero});
    plan.push_back('{CMD_REM_END,   7'd0,   CoordZero, CoordZero});
    plan.push_back('{CMD_REM_FRONT, 7'd64,  CoordZero, CoordZero});
    plan.push_back('{CMD_REM_AT,    7'd0,   CoordZero, CoordZero});
    plan.push_back('{CMD_INS_AT,    7'd0,   32'h1234_5678, 32'h8765_4321});
    foreach (plan[i]) begin
      offer_item(plan[i].op, plan[i].k, plan[i].x, plan[i].y);
      pace_sender();
    end
    wait_for_drain();

    // Random phases: walk toward a fill goal, then hover there a while
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      goal        = (phase < 6) ? goal_plan[phase] : $urandom_range(0, DEPTH);
      hover_left  = $urandom_range(20, 60);
      phase_items = 0;
      reached     = 1'b0;
      while (sent < RandomItems && hover_left > 0 && phase_items < PhaseItemLimit) begin
        fill = list_count;
        if (fill + 1 >= goal && fill <= goal + 1) reached = 1'b1;
        if (reached) hover_left--;
        if (sent == HoldAt) begin
          // Keep offering while the receiver holds off so the block backs up
          long_hold_req <= 1'b1;
          burst_left = 150;
        end
        offer_item(pick_command(fill, goal), pick_position(fill), pick_coord(),
                   pick_coord());
        sent++;
        phase_items++;
        if (sent == PauseAt) wait_for_drain();
        else pace_sender();
      end
      phase++;
    end

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0)
      $display("indexed_point_list_store verification clean");
    else
      $display("indexed_point_list_store verification failed");
    $finish;
  end

  // Receiver: switch between stall patterns, with one long hold-off on request
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned period;
    int unsigned tick;
    bit          hold_done;
    mode       = SINK_OPEN;
    mode_left  = 0;
    period     = 1;
    tick       = 0;
    hold_done  = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(SINK_OPEN, SINK_PERIODIC));
          mode_left = $urandom_range(20, 200);
          period    = $urandom_range(2, 8);
        end
        mode_left--;
        tick++;
        case (mode)
          SINK_OPEN:   out_ready_i <= 1'b1;
          SINK_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ready_i <= ($urandom_range(0, 4) == 0);
          default:     out_ready_i <= (tick % period == 0);
        endcase
      end
    end
  end

  // End the run when neither channel has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("indexed_point_list_store verification failed");
    $finish;
  end

endmodule
